// ===== hw/rtl/btnlad_pkg.sv =====
// btnlad_pkg: shared widths, register indexes, reset values and types
// for the button ladder and ir qualifier block; no dependencies
package btnlad_pkg;

  localparam int unsigned TimeBits  = 32;
  localparam int unsigned AdcBits   = 12;
  localparam int unsigned IrButtons = 4;
  localparam int unsigned IrBtnBits = 2;
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 16;
  localparam int unsigned MsBits      = 16;

  // analog channel slots
  localparam int unsigned AnUp   = 0;
  localparam int unsigned AnMode = 1;
  localparam int unsigned AnDown = 2;
  localparam int unsigned AnCount = 3;

  // ir button codes
  localparam int unsigned IrUp   = 0;
  localparam int unsigned IrDown = 1;
  localparam int unsigned IrMode = 2;
  localparam int unsigned IrPlay = 3;

  // configuration register indexes
  localparam logic [CfgIdxBits-1:0] RegUpLow    = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegUpHigh   = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegModeLow  = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegModeHigh = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegDownThr  = 3'd4;
  localparam logic [CfgIdxBits-1:0] RegDebounce = 3'd5;
  localparam logic [CfgIdxBits-1:0] RegIrTmo    = 3'd6;

  // reset values
  localparam logic [AdcBits-1:0] RstUpLow    = 12'd1300;
  localparam logic [AdcBits-1:0] RstUpHigh   = 12'd1700;
  localparam logic [AdcBits-1:0] RstModeLow  = 12'd2300;
  localparam logic [AdcBits-1:0] RstModeHigh = 12'd2700;
  localparam logic [AdcBits-1:0] RstDownThr  = 12'd3700;
  localparam logic [MsBits-1:0]  RstDebounce = 16'd50;
  localparam logic [MsBits-1:0]  RstIrTmo    = 16'd200;

  typedef struct packed {
    logic [AdcBits-1:0] up_low;
    logic [AdcBits-1:0] up_high;
    logic [AdcBits-1:0] mode_low;
    logic [AdcBits-1:0] mode_high;
    logic [AdcBits-1:0] down_thr;
    logic [MsBits-1:0]  debounce;
    logic [MsBits-1:0]  ir_timeout;
  } cfg_t;

  typedef struct packed {
    logic menu_up;
    logic menu_down;
    logic menu_mode;
    logic play_pause;
  } result_t;

endpackage

// ===== hw/rtl/button_ladder_and_ir_qualifier_core.sv =====
// button_ladder_and_ir_qualifier_core: top level, input and result registers
// depends on btnlad_pkg, btnlad_cfg_regs, btnlad_qual

// each poll transaction carries a ms timestamp, one ladder adc sample and an
// optional ir button event; one result transaction comes back per poll with
// menu up, down, mode and play/pause qualified by the debounce time. a poll
// can be accepted every clock cycle unless in_stall_o is high; its result
// passes through the input register, then the result register that holds the
// compare/subtract logic's output. press state is updated as a poll moves
// from the input register into the result register, so polls back to back see
// each other's effects in order. stalls on the result side hold the result
// register and then the input register; in_stall_o rises only when both are
// full. configuration writes are always ready and take effect on the next
// cycle; write them only while no poll is in flight

module button_ladder_and_ir_qualifier_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // poll input channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [btnlad_pkg::TimeBits-1:0]    now_ms_i,
  input  logic [btnlad_pkg::AdcBits-1:0]     adc_level_i,
  input  logic                               ir_event_i,
  input  logic [btnlad_pkg::IrBtnBits-1:0]   ir_button_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               menu_up_o,
  output logic                               menu_down_o,
  output logic                               menu_mode_o,
  output logic                               play_pause_o,
  // configuration write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [btnlad_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  logic [btnlad_pkg::CfgDataBits-1:0] cfg_data_i
);

  btnlad_pkg::cfg_t    cfg;
  btnlad_pkg::result_t res;

  // input register
  logic                             in_valid_q, in_valid_d;
  logic [btnlad_pkg::TimeBits-1:0]  now_q;
  logic [btnlad_pkg::AdcBits-1:0]   adc_q;
  logic                             ev_q;
  logic [btnlad_pkg::IrBtnBits-1:0] btn_q;

  // result register
  logic                             out_valid_q, out_valid_d;
  btnlad_pkg::result_t              res_q;

  logic in_take;   // poll transaction accepted this cycle
  logic advance;   // input register moves into the result register

  assign cfg_ready_o = 1'b1;

  btnlad_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  // result slot is free when empty or being drained this cycle
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  assign in_valid_d  = in_take || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      now_q <= now_ms_i;
      adc_q <= adc_level_i;
      ev_q  <= ir_event_i;
      btn_q <= ir_button_i;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  // press tracking and qualification, state commits on advance
  btnlad_qual u_qual (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .cfg_i       (cfg),
    .now_i       (now_q),
    .adc_i       (adc_q),
    .ir_event_i  (ev_q),
    .ir_button_i (btn_q),
    .result_o    (res)
  );

  assign out_valid_o  = out_valid_q;
  assign menu_up_o    = res_q.menu_up;
  assign menu_down_o  = res_q.menu_down;
  assign menu_mode_o  = res_q.menu_mode;
  assign play_pause_o = res_q.play_pause;

endmodule

// ===== hw/rtl/btnlad_cfg_regs.sv =====
// btnlad_cfg_regs: configuration register file, written one register per transaction
// depends on btnlad_pkg
module btnlad_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                wr_en_i,
  input  logic [btnlad_pkg::CfgIdxBits-1:0]   wr_idx_i,
  input  logic [btnlad_pkg::CfgDataBits-1:0]  wr_data_i,
  output btnlad_pkg::cfg_t                    cfg_o
);

  btnlad_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_idx_i)
        btnlad_pkg::RegUpLow:    cfg_d.up_low     = wr_data_i[btnlad_pkg::AdcBits-1:0];
        btnlad_pkg::RegUpHigh:   cfg_d.up_high    = wr_data_i[btnlad_pkg::AdcBits-1:0];
        btnlad_pkg::RegModeLow:  cfg_d.mode_low   = wr_data_i[btnlad_pkg::AdcBits-1:0];
        btnlad_pkg::RegModeHigh: cfg_d.mode_high  = wr_data_i[btnlad_pkg::AdcBits-1:0];
        btnlad_pkg::RegDownThr:  cfg_d.down_thr   = wr_data_i[btnlad_pkg::AdcBits-1:0];
        btnlad_pkg::RegDebounce: cfg_d.debounce   = wr_data_i[btnlad_pkg::MsBits-1:0];
        btnlad_pkg::RegIrTmo:    cfg_d.ir_timeout = wr_data_i[btnlad_pkg::MsBits-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.up_low     <= btnlad_pkg::RstUpLow;
      cfg_q.up_high    <= btnlad_pkg::RstUpHigh;
      cfg_q.mode_low   <= btnlad_pkg::RstModeLow;
      cfg_q.mode_high  <= btnlad_pkg::RstModeHigh;
      cfg_q.down_thr   <= btnlad_pkg::RstDownThr;
      cfg_q.debounce   <= btnlad_pkg::RstDebounce;
      cfg_q.ir_timeout <= btnlad_pkg::RstIrTmo;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/btnlad_qual.sv =====
// btnlad_qual: press tracking state and qualification logic for one poll
// depends on btnlad_pkg
module btnlad_qual (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               step_i,
  input  btnlad_pkg::cfg_t                   cfg_i,
  input  logic [btnlad_pkg::TimeBits-1:0]    now_i,
  input  logic [btnlad_pkg::AdcBits-1:0]     adc_i,
  input  logic                               ir_event_i,
  input  logic [btnlad_pkg::IrBtnBits-1:0]   ir_button_i,
  output btnlad_pkg::result_t                result_o
);

  localparam int unsigned TB = btnlad_pkg::TimeBits;
  localparam int unsigned NA = btnlad_pkg::AnCount;
  localparam int unsigned NI = btnlad_pkg::IrButtons;

  logic [NA-1:0]         an_pressed_q, an_pressed_d;
  logic [TB-1:0]         an_start_q [NA];
  logic [NI-1:0]         ir_pressed_q, ir_pressed_d;
  logic [TB-1:0]         ir_start_q [NI];
  logic [TB-1:0]         ir_seen_q  [NI];

  logic [NA-1:0]         an_win;
  logic [NA-1:0]         an_qual;
  logic [NI-1:0]         ir_hit;
  logic [NI-1:0]         ir_tmo;
  logic [NI-1:0]         ir_qual;
  logic [TB-1:0]         deb_ext, tmo_ext;

  assign deb_ext = TB'(cfg_i.debounce);
  assign tmo_ext = TB'(cfg_i.ir_timeout);

  // ladder windows, an inverted window never matches
  assign an_win[btnlad_pkg::AnUp]   = (adc_i >= cfg_i.up_low) && (adc_i <= cfg_i.up_high);
  assign an_win[btnlad_pkg::AnMode] = (adc_i >= cfg_i.mode_low) && (adc_i <= cfg_i.mode_high);
  assign an_win[btnlad_pkg::AnDown] = (adc_i >= cfg_i.down_thr);

  always_comb begin
    for (int a = 0; a < NA; a++) begin
      an_pressed_d[a] = an_win[a];
      // a fresh press has zero elapsed time, so only a running one qualifies
      an_qual[a] = an_win[a] && an_pressed_q[a] && ((now_i - an_start_q[a]) > deb_ext);
    end
  end

  always_comb begin
    for (int b = 0; b < NI; b++) begin
      ir_hit[b] = ir_event_i && (ir_button_i == btnlad_pkg::IrBtnBits'(b));
      ir_tmo[b] = (now_i - ir_seen_q[b]) > tmo_ext;
      // a refreshed button sees zero elapsed since last seen, so no timeout
      ir_pressed_d[b] = ir_hit[b] || (ir_pressed_q[b] && !ir_tmo[b]);
      ir_qual[b] = ir_pressed_q[b] && (ir_hit[b] || !ir_tmo[b]) &&
                   ((now_i - ir_start_q[b]) > deb_ext);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      an_pressed_q <= '0;
      ir_pressed_q <= '0;
    end else if (step_i) begin
      an_pressed_q <= an_pressed_d;
      ir_pressed_q <= ir_pressed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      for (int a = 0; a < NA; a++) begin
        if (!an_pressed_q[a]) begin
          an_start_q[a] <= now_i;
        end
      end
      for (int b = 0; b < NI; b++) begin
        if (ir_hit[b]) begin
          ir_seen_q[b] <= now_i;
          if (!ir_pressed_q[b]) begin
            ir_start_q[b] <= now_i;
          end
        end
      end
    end
  end

  assign result_o.menu_up    = an_qual[btnlad_pkg::AnUp]   || ir_qual[btnlad_pkg::IrUp];
  assign result_o.menu_down  = an_qual[btnlad_pkg::AnDown] || ir_qual[btnlad_pkg::IrDown];
  assign result_o.menu_mode  = an_qual[btnlad_pkg::AnMode] || ir_qual[btnlad_pkg::IrMode];
  assign result_o.play_pause = ir_qual[btnlad_pkg::IrPlay];

endmodule
